// File: src/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types, constants and the CRC-32 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int HEADER_LEN = 3;
  localparam int CRC_LEN    = 4;
  localparam int MIN_FRAME  = HEADER_LEN + CRC_LEN;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  localparam logic [7:0] RST_START  = 8'd193;
  localparam logic [7:0] RST_END    = 8'd192;
  localparam logic [7:0] RST_ESCAPE = 8'd219;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_LEN_ERR  = 2'd1;
  localparam logic [1:0] STAT_CRC_ERR  = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] esc_code;
  } cfg_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/bsfr_ram.sv
// ----------------------------------------------------------------------------
// bsfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 39
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bsfr_front.sv
// ----------------------------------------------------------------------------
// bsfr_front
// Classifies received bytes: frame delimiting and escape removal.
// ----------------------------------------------------------------------------
module bsfr_front
  import bsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       rx_valid,
  input  logic [7:0] rx_byte,
  output logic       rx_ready,
  input  logic       q_ready,
  output logic       push,
  output cmd_t       push_cmd
);

  logic in_frame, in_frame_next;
  logic esc_pending, esc_pending_next;
  logic accept;

  assign rx_ready = q_ready;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    in_frame_next    = in_frame;
    esc_pending_next = esc_pending;
    push             = 1'b0;
    push_cmd.is_end  = 1'b0;
    push_cmd.data    = rx_byte;
    if (accept) begin
      priority if (!in_frame) begin
        if (rx_byte == cfg.start_code) begin
          in_frame_next    = 1'b1;
          esc_pending_next = 1'b0;
        end
      end else if (esc_pending) begin
        push             = 1'b1;
        push_cmd.data    = rx_byte ^ cfg.esc_code;
        esc_pending_next = 1'b0;
      end else if (rx_byte == cfg.esc_code) begin
        esc_pending_next = 1'b1;
      end else if (rx_byte == cfg.end_code) begin
        push             = 1'b1;
        push_cmd.is_end  = 1'b1;
        in_frame_next    = 1'b0;
        esc_pending_next = 1'b0;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      esc_pending <= 1'b0;
    end else begin
      in_frame    <= in_frame_next;
      esc_pending <= esc_pending_next;
    end
  end

endmodule

// File: src/bsfr_queue.sv
// ----------------------------------------------------------------------------
// bsfr_queue
// Two-entry command queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module bsfr_queue
  import bsfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/bsfr_back.sv
// ----------------------------------------------------------------------------
// bsfr_back
// Frame engine: stores frame bytes, runs the CRC, checks and emits results.
// ----------------------------------------------------------------------------
module bsfr_back
  import bsfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [7:0] dest_id,
  output logic [7:0] source_id,
  output logic [7:0] payload_len,
  output logic [1:0] frame_status,
  output logic       last
);

  localparam int STORE_LEN = MAX_PAYLOAD + HEADER_LEN + CRC_LEN;
  localparam int AW        = $clog2(STORE_LEN);
  localparam int CW        = $clog2(STORE_LEN + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEND = 4'b0010,
    ST_READ = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   byte_count;
  logic            overflowed;
  logic [31:0]     crc;
  logic [7:0]      hdr [HEADER_LEN];
  logic [7:0]      tail [CRC_LEN];
  logic [7:0]      remaining;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      ram_rdata;

  logic            at_full;
  logic [AW-1:0]   wr_idx;
  logic            do_store;
  logic            do_end;
  logic [7:0]      cnt8;
  logic [7:0]      hdr_show [HEADER_LEN];
  logic            len_ok;
  logic            crc_ok;
  logic [1:0]      status;

  assign pop      = (state == ST_IDLE) && q_valid;
  assign do_store = pop && !q_cmd.is_end;
  assign do_end   = pop && q_cmd.is_end;
  assign at_full  = (byte_count == CW'(STORE_LEN));
  assign wr_idx   = at_full ? '0 : byte_count[AW-1:0];
  assign cnt8     = 8'(byte_count);

  always_comb begin
    for (int i = 0; i < HEADER_LEN; i++) begin
      hdr_show[i] = (overflowed || (cnt8 > 8'(i))) ? hdr[i] : 8'd0;
    end
    len_ok = (cnt8 >= 8'(MIN_FRAME)) && (hdr_show[2] == cnt8 - 8'(MIN_FRAME));
    crc_ok = ((crc ^ CRC_INIT) == {tail[3], tail[2], tail[1], tail[0]});
    priority if (overflowed) begin
      status = STAT_OVERFLOW;
    end else if (!len_ok) begin
      status = STAT_LEN_ERR;
    end else if (!crc_ok) begin
      status = STAT_CRC_ERR;
    end else begin
      status = STAT_OK;
    end
  end

  bsfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_LEN)
  ) u_store (
    .clk   (clk),
    .we    (do_store),
    .waddr (wr_idx),
    .wdata (q_cmd.data),
    .re    (state == ST_READ),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (do_end) state_next = ST_SEND;
      ST_SEND: begin
        if (res_ready) begin
          state_next = last ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SEND;
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_valid = (state == ST_SEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_count <= '0;
      overflowed <= 1'b0;
      crc        <= CRC_INIT;
    end else begin
      state <= state_next;
      if (do_store) begin
        if (at_full) begin
          overflowed <= 1'b1;
        end
        byte_count <= CW'(wr_idx) + CW'(1);
        if (wr_idx >= AW'(MIN_FRAME)) begin
          crc <= crc_byte(crc, tail[3]);
        end
      end else if (do_end) begin
        byte_count <= '0;
        overflowed <= 1'b0;
        crc        <= CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      if (wr_idx < AW'(HEADER_LEN)) begin
        hdr[wr_idx[1:0]] <= q_cmd.data;
      end
      tail[0] <= q_cmd.data;
      for (int i = 1; i < CRC_LEN; i++) begin
        tail[i] <= tail[i-1];
      end
    end
    if (do_end) begin
      kind         <= KIND_STATUS;
      data_byte    <= 8'd0;
      dest_id      <= hdr_show[0];
      source_id    <= hdr_show[1];
      payload_len  <= hdr_show[2];
      frame_status <= status;
      last         <= (status != STAT_OK) || (hdr_show[2] == 8'd0);
      remaining    <= hdr_show[2];
      rd_addr      <= AW'(HEADER_LEN);
    end
    if (state == ST_LOAD) begin
      kind         <= KIND_DATA;
      data_byte    <= ram_rdata;
      frame_status <= STAT_OK;
      last         <= (remaining == 8'd1);
      remaining    <= remaining - 8'd1;
      rd_addr      <= rd_addr + AW'(1);
    end
  end

endmodule

// File: src/byte_stuffed_frame_receiver_crc32_unit.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc32_unit
// Byte-stuffed frame receiver with header capture and CRC-32 payload check.
//
// Channel   Direction  Handshake            Contents
// rx        in         rx_valid / rx_ready  rx_byte
// res       out        res_valid/res_ready  kind, data_byte, header, status, last
// apb       in         psel/penable/pready  start, end and escape codes
//
// Each received byte is accepted while the two-entry queue has room.
// A closing byte yields a status word in the cycle after it leaves the queue.
// Each payload word is then fetched through the read and load states of the registered store read.
// Input stalls once the queue fills while results are being emitted.
// Reset is synchronous and clears the framing state; the store is not cleared.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_crc32_unit
  import bsfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  dest_id,
  output logic [7:0]  source_id,
  output logic [7:0]  payload_len,
  output logic [1:0]  frame_status,
  output logic        last
);

  cfg_t       cfg;
  logic       reg_write;
  logic       q_ready;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       q_valid;
  cmd_t       q_cmd;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code <= RST_START;
      cfg.end_code   <= RST_END;
      cfg.esc_code   <= RST_ESCAPE;
    end else if (reg_write) begin
      unique case (paddr[3:2])
        REG_START:  cfg.start_code <= pwdata[7:0];
        REG_END:    cfg.end_code   <= pwdata[7:0];
        REG_ESCAPE: cfg.esc_code   <= pwdata[7:0];
        default:    cfg            <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START:  prdata = {24'd0, cfg.start_code};
      REG_END:    prdata = {24'd0, cfg.end_code};
      REG_ESCAPE: prdata = {24'd0, cfg.esc_code};
      default:    prdata = 32'd0;
    endcase
  end

  bsfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_ready (rx_ready),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bsfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  bsfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .dest_id      (dest_id),
    .source_id    (source_id),
    .payload_len  (payload_len),
    .frame_status (frame_status),
    .last         (last)
  );

endmodule

// File: src/bsfr_checker.sv
// ----------------------------------------------------------------------------
// bsfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module bsfr_checker
  import bsfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       kind,
  input logic [7:0] data_byte,
  input logic [7:0] payload_len,
  input logic [1:0] frame_status,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(last))
    else $error("Stalled result word changed.");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_DATA) |-> (frame_status == STAT_OK))
    else $error("Payload word carries a failing status.");

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_STATUS) && (frame_status != STAT_OK) |-> last)
    else $error("Failed frame status word is not marked last.");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_STATUS) && (payload_len == 8'd0) |-> last)
    else $error("Empty frame status word is not marked last.");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_STATUS) |-> (data_byte == 8'd0))
    else $error("Status word carries a nonzero data byte.");

endmodule

bind byte_stuffed_frame_receiver_crc32_unit bsfr_checker u_bsfr_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .kind         (kind),
  .data_byte    (data_byte),
  .payload_len  (payload_len),
  .frame_status (frame_status),
  .last         (last)
);

// File: tb/tb_byte_stuffed_frame_receiver_crc32_unit.sv
// ----------------------------------------------------------------------------
// tb_byte_stuffed_frame_receiver_crc32_unit
// Self-checking bench for the byte-stuffed frame receiver with CRC-32 check.
//
// Received bytes go in over a valid/ready channel; every accepted byte runs
// through a deframing predictor that queues the words the block owes. Each
// output word is compared field by field with the oldest owed word. A short
// table of hand-built frames runs first with the reset codes. Random frames
// follow under several code settings written over the register port: good,
// corrupted, short, overflowing and junk frames, plus line noise. Sender
// gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_byte_stuffed_frame_receiver_crc32_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_LEN = MAX_PAYLOAD + MIN_FRAME;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 8;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] len;
    logic [1:0] status;
    logic       last;
  } frame_word_t;

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    frame_word_t w;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  dest_id;
  logic [7:0]  source_id;
  logic [7:0]  payload_len;
  logic [1:0]  frame_status;
  logic        last;

  byte_stuffed_frame_receiver_crc32_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .kind(kind),
    .data_byte(data_byte),
    .dest_id(dest_id),
    .source_id(source_id),
    .payload_len(payload_len),
    .frame_status(frame_status),
    .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state.
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_end;
  logic [7:0]  cfg_esc;
  bit          in_frame;
  bit          esc_pend;
  bit          ovf;
  int unsigned nstored;
  logic [7:0]  store [STORE_LEN];

  frame_word_t owed_words [$];
  stim_row_t   directed_rows [$];
  logic [7:0]  burst_q [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic logic [31:0] crc32_of(input byte_q_t d);
    logic [31:0] c;
    int k;
    c = 32'hFFFF_FFFF;
    foreach (d[i]) begin
      c = c ^ {24'd0, d[i]};
      for (k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  function automatic void reset_model();
    cfg_start = RST_START;
    cfg_end = RST_END;
    cfg_esc = RST_ESCAPE;
    in_frame = 1'b0;
    esc_pend = 1'b0;
    ovf = 1'b0;
    nstored = 0;
    foreach (store[i]) store[i] = '0;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (nstored >= STORE_LEN) begin
      ovf = 1'b1;
      nstored = 0;
    end
    store[nstored] = b;
    nstored++;
  endfunction

  function automatic void close_frame(bit typed, frame_word_t typed_w);
    logic [7:0]  hdr [HEADER_LEN];
    logic [1:0]  st;
    int unsigned plen;
    logic [31:0] got;
    byte_q_t     pl;
    frame_word_t w;
    plen = 0;
    for (int i = 0; i < HEADER_LEN; i++) begin
      hdr[i] = (ovf || i < nstored) ? store[i] : 8'h00;
    end
    if (ovf) begin
      st = STAT_OVERFLOW;
    end else if (nstored < MIN_FRAME || hdr[2] != nstored - MIN_FRAME) begin
      st = STAT_LEN_ERR;
    end else begin
      plen = hdr[2];
      for (int i = 0; i < plen; i++) pl.push_back(store[HEADER_LEN + i]);
      got = {store[HEADER_LEN + plen], store[HEADER_LEN + plen + 1],
             store[HEADER_LEN + plen + 2], store[HEADER_LEN + plen + 3]};
      st = (crc32_of(pl) == got) ? STAT_OK : STAT_CRC_ERR;
    end
    w = '{KIND_STATUS, 8'h00, hdr[0], hdr[1], hdr[2], st,
          (st != STAT_OK || plen == 0)};
    owed_words.push_back(typed ? typed_w : w);
    if (st == STAT_OK) begin
      for (int i = 0; i < plen; i++) begin
        owed_words.push_back('{KIND_DATA, store[HEADER_LEN + i], hdr[0], hdr[1],
                               hdr[2], STAT_OK, (i + 1 == plen)});
      end
    end
    in_frame = 1'b0;
    esc_pend = 1'b0;
    nstored = 0;
    ovf = 1'b0;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, bit typed, frame_word_t typed_w);
    if (!in_frame) begin
      if (b == cfg_start) begin
        in_frame = 1'b1;
        esc_pend = 1'b0;
        nstored = 0;
        ovf = 1'b0;
      end
    end else if (esc_pend) begin
      store_byte(b ^ cfg_esc);
      esc_pend = 1'b0;
    end else if (b == cfg_esc) begin
      esc_pend = 1'b1;
    end else if (b == cfg_end) begin
      close_frame(typed, typed_w);
    end else begin
      store_byte(b);
    end
  endfunction

  function automatic frame_word_t status_word(logic [7:0] d, logic [7:0] s,
                                              logic [7:0] l, logic [1:0] st);
    return '{KIND_STATUS, 8'h00, d, s, l, st, 1'b1};
  endfunction

  function automatic void add_row(logic [7:0] b, bit typed = 1'b0, frame_word_t w = '0);
    stim_row_t r;
    r.rx = b;
    r.typed = typed;
    r.w = w;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return cfg_start;
      1: return cfg_end;
      2: return cfg_esc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void stuff_byte(logic [7:0] v);
    if (v == cfg_esc || v == cfg_end || $urandom_range(7) == 0) begin
      burst_q.push_back(cfg_esc);
      burst_q.push_back(v ^ cfg_esc);
    end else begin
      burst_q.push_back(v);
    end
  endfunction

  // Returns the number of frame bytes queued; line noise counts as none.
  function automatic int unsigned add_frame();
    int unsigned k, r, len, n0;
    logic [31:0] crc;
    byte_q_t     body;
    byte_q_t     pl;
    k = $urandom_range(99);
    n0 = burst_q.size();
    if (k >= 85 && k < 92) begin
      repeat ($urandom_range(1, 4)) burst_q.push_back(8'($urandom_range(255)));
      return 0;
    end
    burst_q.push_back(cfg_start);
    if (k >= 92) begin
      repeat ($urandom_range(0, 10)) burst_q.push_back(random_byte());
      burst_q.push_back(cfg_end);
      return burst_q.size() - n0;
    end
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(0, 6);
    else if (r < 90) len = $urandom_range(7, 16);
    else if (r < 97) len = $urandom_range(17, MAX_PAYLOAD - 1);
    else len = MAX_PAYLOAD;
    if (k >= 81) len = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 6);
    body.push_back(random_byte());
    body.push_back(random_byte());
    body.push_back(8'(len));
    for (int i = 0; i < len; i++) pl.push_back(random_byte());
    crc = crc32_of(pl);
    if (k >= 62 && k < 70) crc = crc ^ (32'h1 << $urandom_range(31));
    if (k >= 70 && k < 76) body[2] = body[2] + 8'($urandom_range(1, 255));
    foreach (pl[i]) body.push_back(pl[i]);
    body.push_back(crc[31:24]);
    body.push_back(crc[23:16]);
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    if (k >= 76 && k < 81) begin
      r = $urandom_range(0, MIN_FRAME - 1);
      while (body.size() > r) void'(body.pop_back());
    end
    foreach (body[i]) stuff_byte(body[i]);
    burst_q.push_back(cfg_end);
    return burst_q.size() - n0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("tb: mismatch in %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    end
    mismatch_count++;
  endtask

  task automatic apb_xfer(logic [1:0] idx, bit wr, logic [7:0] wdata,
                          output logic [7:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, wdata};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic [1:0] idx, logic [7:0] want);
    logic [7:0] got;
    apb_xfer(idx, 1'b0, 8'h00, got);
    if (got !== want) report_mismatch("register readback", got, want);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] v);
    logic [7:0] unused;
    apb_xfer(idx, 1'b1, v, unused);
    case (idx)
      REG_START: cfg_start = v;
      REG_END: cfg_end = v;
      REG_ESCAPE: cfg_esc = v;
      default: ;
    endcase
    check_reg(idx, v);
  endtask

  task automatic send_word(logic [7:0] b, bit typed, frame_word_t w);
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!rx_ready);
    deframe_byte(b, typed, w);
    if ($urandom_range(99) < idle_pct) begin
      rx_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic settle();
    while (owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_out
    frame_word_t want;
    res_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && res_valid && res_ready) begin
      if (owed_words.size() == 0) begin
        report_mismatch("word with none owed", {kind, data_byte}, 0);
      end else begin
        want = owed_words.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (data_byte !== want.data) report_mismatch("data_byte", data_byte, want.data);
        if (dest_id !== want.dest) report_mismatch("dest_id", dest_id, want.dest);
        if (source_id !== want.src) report_mismatch("source_id", source_id, want.src);
        if (payload_len !== want.len) report_mismatch("payload_len", payload_len, want.len);
        if (frame_status !== want.status) begin
          report_mismatch("frame_status", frame_status, want.status);
        end
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    int unsigned target, sent;
    logic [7:0] s, e, x;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_START, RST_START);
    check_reg(REG_END, RST_END);
    check_reg(REG_ESCAPE, RST_ESCAPE);

    add_row(8'h00);
    add_row(8'hFF);
    add_row(RST_START);
    add_row(RST_END, 1'b1, status_word(8'h00, 8'h00, 8'h00, STAT_LEN_ERR));
    add_row(RST_START);
    add_row(8'h12);
    add_row(8'h34);
    add_row(RST_END, 1'b1, status_word(8'h12, 8'h34, 8'h00, STAT_LEN_ERR));
    add_row(RST_START);
    add_row(8'hAA);
    add_row(8'h55);
    repeat (5) add_row(8'h00);
    add_row(RST_END, 1'b1, status_word(8'hAA, 8'h55, 8'h00, STAT_OK));
    add_row(RST_START);
    add_row(8'hFF);
    add_row(RST_START);
    add_row(8'h01);
    add_row(RST_ESCAPE);
    add_row(RST_ESCAPE);
    add_row(8'hD2);
    add_row(8'h02);
    add_row(8'hEF);
    add_row(8'h8D);
    add_row(RST_END);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].w);
    end
    rx_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin s = 8'h00; e = 8'hFF; x = 8'h7D; end
        1: begin s = 8'hFF; e = 8'h00; x = 8'h80; end
        3: begin s = 8'h7E; e = 8'h7E; x = 8'hFF; end
        4: begin s = 8'h55; e = 8'hAA; x = 8'hAA; end
        6: begin s = RST_START; e = RST_END; x = RST_ESCAPE; end
        7: begin s = 8'hFE; e = 8'h01; x = 8'h00; end
        default: begin
          s = 8'($urandom_range(255));
          e = 8'($urandom_range(255));
          x = 8'($urandom_range(255));
        end
      endcase
      set_reg(REG_START, s);
      set_reg(REG_END, e);
      set_reg(REG_ESCAPE, x);
      idle_pct = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 27 : 0;
      stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 27 : 0;
      target = (p == 4) ? 30 : 40;
      sent = 0;
      burst_q.delete();
      while (sent < target) sent += add_frame();
      foreach (burst_q[i]) send_word(burst_q[i], 1'b0, '0);
      rx_valid <= 1'b0;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
